[rtl/core/bvo_pkg.sv]
// Package for the bit-vector operator evaluator: operator codes, queue word
// and pipeline side-band types, width helpers. No dependencies.
`timescale 1ns / 1ps

package bvo_pkg;

  localparam int DATA_W      = 64;
  localparam int WID_W       = 7;
  localparam int MAX_WIDTH   = 64;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [4:0] {
    OP_NOT    = 5'd0,  OP_REDAND = 5'd1,  OP_REDOR  = 5'd2,  OP_REDXOR = 5'd3,
    OP_SLICE  = 5'd4,  OP_UEXT   = 5'd5,  OP_SEXT   = 5'd6,  OP_ITE    = 5'd7,
    OP_AND    = 5'd8,  OP_OR     = 5'd9,  OP_XOR    = 5'd10, OP_ADD    = 5'd11,
    OP_SUB    = 5'd12, OP_MUL    = 5'd13, OP_UDIV   = 5'd14, OP_UREM   = 5'd15,
    OP_EQ     = 5'd16, OP_NEQ    = 5'd17, OP_ULT    = 5'd18, OP_ULTE   = 5'd19,
    OP_UGT    = 5'd20, OP_UGTE   = 5'd21, OP_SLT    = 5'd22, OP_SLTE   = 5'd23,
    OP_SGT    = 5'd24, OP_SGTE   = 5'd25, OP_CONCAT = 5'd26, OP_SLL    = 5'd27,
    OP_SRL    = 5'd28, OP_SRA    = 5'd29
  } op_e;

  typedef enum logic [1:0] {
    SEL_RES = 2'd0,
    SEL_QUO = 2'd1,
    SEL_REM = 2'd2
  } sel_e;

  // classified item handed from the front to the back
  typedef struct packed {
    logic [4:0]        mode;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] sa;
    logic [DATA_W-1:0] sb;
    logic [DATA_W-1:0] itev;
    logic [DATA_W-1:0] rmask;
    logic [WID_W-1:0]  sh;
    logic [WID_W-1:0]  wb;
    logic [5:0]        lo;
    logic              a_all;
  } op_t;

  // travels alongside the divider stages
  typedef struct packed {
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] rmask;
    sel_e              sel;
    logic              ok;
  } side_t;

  function automatic logic [WID_W-1:0] clamp_w(input logic [WID_W-1:0] w);
    logic [WID_W-1:0] r;
    r = w;
    if (w == '0) r = WID_W'(1);
    else if (w > WID_W'(MAX_WIDTH)) r = WID_W'(MAX_WIDTH);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] wmask(input logic [WID_W-1:0] w);
    return ~({DATA_W{1'b1}} << w);
  endfunction

endpackage

[rtl/core/bitvector_operator_evaluator_unit.sv]
// Bit-vector operator evaluator: front end, word queue, back-end pipeline.
// A word passes the front register, the queue, the evaluate stage, then 64
// divider stages (one quotient bit per stage). Throughput one word per cycle;
// the back end stalls as a whole while the result at its end is not popped.
// Synchronous active-low reset empties all.
`timescale 1ns / 1ps

module bitvector_operator_evaluator_unit
  import bvo_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [4:0]        in_mode,
  input  logic [DATA_W-1:0] in_operand_a,
  input  logic [DATA_W-1:0] in_operand_b,
  input  logic [DATA_W-1:0] in_operand_c,
  input  logic [WID_W-1:0]  in_width_a,
  input  logic [WID_W-1:0]  in_width_b,
  input  logic [WID_W-1:0]  in_result_width,
  input  logic [5:0]        in_slice_low,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [DATA_W-1:0] out_result,
  output logic              out_valid_res
);

  logic q_push, q_full, q_pop, q_empty, en, ex_v;
  op_t  q_din, q_dout;

  bvo_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_mode         (in_mode),
    .in_operand_a    (in_operand_a),
    .in_operand_b    (in_operand_b),
    .in_operand_c    (in_operand_c),
    .in_width_a      (in_width_a),
    .in_width_b      (in_width_b),
    .in_result_width (in_result_width),
    .in_slice_low    (in_slice_low),
    .q_push          (q_push),
    .q_din           (q_din),
    .q_full          (q_full)
  );

  bvo_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // the last pipeline stage is the result register
  assign en    = !ex_v || out_pop;
  assign q_pop = en && !q_empty;

  bvo_exec u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_v       (q_pop),
    .in_op      (q_dout),
    .out_v      (ex_v),
    .out_result (out_result),
    .out_ok     (out_valid_res)
  );

  assign out_empty = !ex_v;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result channel not empty after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_valid_res) |-> (out_result == '0))
    else $error("invalid result carries nonzero data");

  a_full_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> q_full)
    else $error("input stalled while queue has room");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_result)))
    else $error("waiting result changed");

endmodule

[rtl/core/bvo_fifo.sv]
// Small register queue between the front and the back of the evaluator.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module bvo_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    if (do_pop)  rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= din;
  end

endmodule

[rtl/core/bvo_front.sv]
// Front end: registers an incoming word, clamps widths, masks operands and
// precomputes sign extensions. Depends on bvo_pkg.
`timescale 1ns / 1ps

module bvo_front
  import bvo_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [4:0]        in_mode,
  input  logic [DATA_W-1:0] in_operand_a,
  input  logic [DATA_W-1:0] in_operand_b,
  input  logic [DATA_W-1:0] in_operand_c,
  input  logic [WID_W-1:0]  in_width_a,
  input  logic [WID_W-1:0]  in_width_b,
  input  logic [WID_W-1:0]  in_result_width,
  input  logic [5:0]        in_slice_low,
  output logic              q_push,
  output op_t               q_din,
  input  logic              q_full
);

  logic             fr_v_r, fr_v_nxt;
  op_t              fr_op_r, op_nxt;
  logic [WID_W-1:0] wa, wb, wr;
  logic [DATA_W-1:0] ma, mb;
  logic [5:0]       ta, tb;

  assign in_full = fr_v_r && q_full;
  assign q_push  = fr_v_r;
  assign q_din   = fr_op_r;

  always_comb begin
    wa = clamp_w(in_width_a);
    wb = clamp_w(in_width_b);
    wr = clamp_w(in_result_width);
    ma = wmask(wa);
    mb = wmask(wb);
    ta = 6'(wa - WID_W'(1));
    tb = 6'(wb - WID_W'(1));
    op_nxt.mode  = in_mode;
    op_nxt.a     = in_operand_a & ma;
    op_nxt.b     = in_operand_b & mb;
    op_nxt.sa    = op_nxt.a[ta] ? (op_nxt.a | ~ma) : op_nxt.a;
    op_nxt.sb    = op_nxt.b[tb] ? (op_nxt.b | ~mb) : op_nxt.b;
    op_nxt.itev  = (op_nxt.a != '0) ? in_operand_b : in_operand_c;
    op_nxt.rmask = wmask(wr);
    op_nxt.sh    = (op_nxt.b > DATA_W'(wr)) ? wr : WID_W'(op_nxt.b);
    op_nxt.wb    = wb;
    op_nxt.lo    = in_slice_low;
    op_nxt.a_all = (op_nxt.a == ma);
  end

  assign fr_v_nxt = in_push;

  always_ff @(posedge clk) begin
    if (!rst_n) fr_v_r <= 1'b0;
    else if (!in_full) fr_v_r <= fr_v_nxt;
  end

  always_ff @(posedge clk) begin
    if (!in_full && in_push) fr_op_r <= op_nxt;
  end

endmodule

[rtl/core/bvo_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a side-band
// word carried in step. Depends on bvo_pkg.
`timescale 1ns / 1ps

module bvo_div
  import bvo_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  input  side_t             in_side,
  output logic              out_v,
  output logic [DATA_W-1:0] quo,
  output logic [DATA_W-1:0] rem,
  output side_t             out_side
);

  localparam int N = DATA_W;

  logic              vld_r  [N];
  logic [DATA_W-1:0] rem_r  [N];
  logic [DATA_W-1:0] quo_r  [N];
  logic [DATA_W-1:0] dvs_r  [N];
  side_t             side_r [N];
  logic [DATA_W-1:0] rem_nxt [N];
  logic [DATA_W-1:0] quo_nxt [N];

  // stage i works on what stage i-1 holds; stage 0 on the inputs
  always_comb begin
    logic [DATA_W:0]   part;
    logic [DATA_W-1:0] r_in, q_in, d_in;
    for (int i = 0; i < N; i++) begin
      r_in = (i == 0) ? '0 : rem_r[(i == 0) ? 0 : i - 1];
      q_in = (i == 0) ? dividend : quo_r[(i == 0) ? 0 : i - 1];
      d_in = (i == 0) ? divisor : dvs_r[(i == 0) ? 0 : i - 1];
      part = {r_in, q_in[DATA_W-1]};
      if (part >= {1'b0, d_in}) begin
        rem_nxt[i] = DATA_W'(part - {1'b0, d_in});
        quo_nxt[i] = {q_in[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt[i] = part[DATA_W-1:0];
        quo_nxt[i] = {q_in[DATA_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_v;
      for (int i = 1; i < N; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= rem_nxt[0];
      quo_r[0]  <= quo_nxt[0];
      dvs_r[0]  <= divisor;
      side_r[0] <= in_side;
      for (int i = 1; i < N; i++) begin
        rem_r[i]  <= rem_nxt[i];
        quo_r[i]  <= quo_nxt[i];
        dvs_r[i]  <= dvs_r[i-1];
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign out_v    = vld_r[N-1];
  assign quo      = quo_r[N-1];
  assign rem      = rem_r[N-1];
  assign out_side = side_r[N-1];

endmodule

[rtl/core/bvo_exec.sv]
// Back end: evaluates the operator, splits the multiply over two stages and
// runs every word through the divider pipeline. Depends on bvo_pkg, bvo_div.
`timescale 1ns / 1ps

module bvo_exec
  import bvo_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  op_t               in_op,
  output logic              out_v,
  output logic [DATA_W-1:0] out_result,
  output logic              out_ok
);

  localparam int HW = DATA_W / 2;

  logic              e1_v_r;
  logic [DATA_W-1:0] e1_res_r, e1_a_r, e1_b_r, e1_mask_r, e1_p0_r;
  logic [HW-1:0]     e1_p1_r, e1_p2_r;
  sel_e              e1_sel_r;
  logic              e1_ok_r, e1_mul_r;

  logic [DATA_W-1:0] res_c;
  sel_e              sel_c;
  logic              ok_c, mul_c;
  side_t             side_c, side_o;
  logic [DATA_W-1:0] quo, rem, pick;

  always_comb begin
    res_c = '0;
    sel_c = SEL_RES;
    ok_c  = 1'b1;
    mul_c = 1'b0;
    unique case (op_e'(in_op.mode))
      OP_NOT:    res_c = ~in_op.a;
      OP_REDAND: res_c = DATA_W'(in_op.a_all);
      OP_REDOR:  res_c = DATA_W'(in_op.a != '0);
      OP_REDXOR: res_c = DATA_W'(^in_op.a);
      OP_SLICE:  res_c = in_op.a >> in_op.lo;
      OP_UEXT:   res_c = in_op.a;
      OP_SEXT:   res_c = in_op.sa;
      OP_ITE:    res_c = in_op.itev;
      OP_AND:    res_c = in_op.a & in_op.b;
      OP_OR:     res_c = in_op.a | in_op.b;
      OP_XOR:    res_c = in_op.a ^ in_op.b;
      OP_ADD:    res_c = in_op.a + in_op.b;
      OP_SUB:    res_c = in_op.a - in_op.b;
      OP_MUL:    mul_c = 1'b1;
      OP_UDIV: begin
        sel_c = SEL_QUO;
        ok_c  = (in_op.b != '0);
      end
      OP_UREM: begin
        sel_c = SEL_REM;
        ok_c  = (in_op.b != '0);
      end
      OP_EQ:     res_c = DATA_W'(in_op.a == in_op.b);
      OP_NEQ:    res_c = DATA_W'(in_op.a != in_op.b);
      OP_ULT:    res_c = DATA_W'(in_op.a < in_op.b);
      OP_ULTE:   res_c = DATA_W'(in_op.a <= in_op.b);
      OP_UGT:    res_c = DATA_W'(in_op.a > in_op.b);
      OP_UGTE:   res_c = DATA_W'(in_op.a >= in_op.b);
      OP_SLT:    res_c = DATA_W'($signed(in_op.sa) < $signed(in_op.sb));
      OP_SLTE:   res_c = DATA_W'($signed(in_op.sa) <= $signed(in_op.sb));
      OP_SGT:    res_c = DATA_W'($signed(in_op.sa) > $signed(in_op.sb));
      OP_SGTE:   res_c = DATA_W'($signed(in_op.sa) >= $signed(in_op.sb));
      OP_CONCAT: res_c = (in_op.a << in_op.wb) | in_op.b;
      OP_SLL:    res_c = in_op.a << in_op.sh;
      OP_SRL:    res_c = in_op.a >> in_op.sh;
      OP_SRA:    res_c = DATA_W'($signed(in_op.sa) >>> in_op.sh);
      default:   ok_c  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) e1_v_r <= 1'b0;
    else if (en) e1_v_r <= in_v;
  end

  // low word of the product only: the cross terms need just their low halves
  always_ff @(posedge clk) begin
    if (en) begin
      e1_res_r  <= res_c;
      e1_sel_r  <= sel_c;
      e1_ok_r   <= ok_c;
      e1_mul_r  <= mul_c;
      e1_a_r    <= in_op.a;
      e1_b_r    <= in_op.b;
      e1_mask_r <= in_op.rmask;
      e1_p0_r   <= in_op.a[HW-1:0] * in_op.b[HW-1:0];
      e1_p1_r   <= HW'(in_op.a[HW-1:0] * in_op.b[DATA_W-1:HW]);
      e1_p2_r   <= HW'(in_op.a[DATA_W-1:HW] * in_op.b[HW-1:0]);
    end
  end

  always_comb begin
    side_c.res   = e1_mul_r ? (e1_p0_r + {e1_p1_r + e1_p2_r, {HW{1'b0}}}) : e1_res_r;
    side_c.rmask = e1_mask_r;
    side_c.sel   = e1_sel_r;
    side_c.ok    = e1_ok_r;
  end

  bvo_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (e1_v_r),
    .dividend (e1_a_r),
    .divisor  (e1_b_r),
    .in_side  (side_c),
    .out_v    (out_v),
    .quo      (quo),
    .rem      (rem),
    .out_side (side_o)
  );

  always_comb begin
    case (side_o.sel)
      SEL_QUO: pick = quo;
      SEL_REM: pick = rem;
      default: pick = side_o.res;
    endcase
  end

  assign out_result = side_o.ok ? (pick & side_o.rmask) : '0;
  assign out_ok     = side_o.ok;

endmodule

[tb/bvo_checker.sv]
// Checker for the bit-vector operator evaluator: watches push/pop, predicts
// each result word and compares it. Depends on bvo_pkg.
`timescale 1ns / 1ps

module bvo_checker
  import bvo_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic              in_full,
  input  logic [4:0]        in_mode,
  input  logic [DATA_W-1:0] in_operand_a,
  input  logic [DATA_W-1:0] in_operand_b,
  input  logic [DATA_W-1:0] in_operand_c,
  input  logic [WID_W-1:0]  in_width_a,
  input  logic [WID_W-1:0]  in_width_b,
  input  logic [WID_W-1:0]  in_result_width,
  input  logic [5:0]        in_slice_low,
  input  logic              out_empty,
  input  logic              out_pop,
  input  logic [DATA_W-1:0] out_result,
  input  logic              out_valid_res,
  output int                fail_count,
  output int                pending_words
);

  typedef struct packed {
    logic [63:0] result;
    logic        valid_res;
  } eval_word_t;

  eval_word_t expected_words[$];

  function automatic logic [6:0] fit_width(logic [6:0] w);
    if (w == 0) return 7'd1;
    if (w > 64) return 7'd64;
    return w;
  endfunction

  function automatic logic [63:0] low_ones(logic [6:0] w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic logic [63:0] to_signed64(logic [63:0] v, logic [6:0] w);
    if (w >= 64) return v;
    return v[w-1] ? (v | ~low_ones(w)) : v;
  endfunction

  function automatic eval_word_t evaluate_op(
      logic [4:0] mode, logic [63:0] opa, logic [63:0] opb, logic [63:0] opc,
      logic [6:0] w_a, logic [6:0] w_b, logic [6:0] w_r, logic [5:0] lo);
    logic [6:0] wa, wb, wr;
    logic [63:0] a, b, sa, sb, r, sh;
    logic ok;
    eval_word_t w;
    wa = fit_width(w_a);
    wb = fit_width(w_b);
    wr = fit_width(w_r);
    a = opa & low_ones(wa);
    b = opb & low_ones(wb);
    sa = to_signed64(a, wa);
    sb = to_signed64(b, wb);
    sh = (b > wr) ? 64'(wr) : b;
    r = '0;
    ok = 1'b1;
    case (mode)
      OP_NOT:    r = ~a;
      OP_REDAND: r = 64'(a == low_ones(wa));
      OP_REDOR:  r = 64'(a != 0);
      OP_REDXOR: r = 64'(^a);
      OP_SLICE:  r = a >> lo;
      OP_UEXT:   r = a;
      OP_SEXT:   r = sa;
      OP_ITE:    r = (a != 0) ? opb : opc;
      OP_AND:    r = a & b;
      OP_OR:     r = a | b;
      OP_XOR:    r = a ^ b;
      OP_ADD:    r = a + b;
      OP_SUB:    r = a - b;
      OP_MUL:    r = a * b;
      OP_UDIV:   if (b == 0) ok = 1'b0; else r = a / b;
      OP_UREM:   if (b == 0) ok = 1'b0; else r = a % b;
      OP_EQ:     r = 64'(a == b);
      OP_NEQ:    r = 64'(a != b);
      OP_ULT:    r = 64'(a < b);
      OP_ULTE:   r = 64'(a <= b);
      OP_UGT:    r = 64'(a > b);
      OP_UGTE:   r = 64'(a >= b);
      OP_SLT:    r = 64'($signed(sa) < $signed(sb));
      OP_SLTE:   r = 64'($signed(sa) <= $signed(sb));
      OP_SGT:    r = 64'($signed(sa) > $signed(sb));
      OP_SGTE:   r = 64'($signed(sa) >= $signed(sb));
      OP_CONCAT: r = ((wb >= 64) ? 64'd0 : (a << wb)) | b;
      OP_SLL:    r = (sh >= 64) ? 64'd0 : (a << sh);
      OP_SRL:    r = (sh >= 64) ? 64'd0 : (a >> sh);
      OP_SRA:    r = (sh >= 64) ? {64{sa[63]}} : 64'($signed(sa) >>> sh);
      default:   ok = 1'b0;
    endcase
    if (!ok) r = '0;
    w.result = r & low_ones(wr);
    w.valid_res = ok;
    return w;
  endfunction

  always @(posedge clk) begin
    eval_word_t exp_w;
    int         errs;
    errs = 0;
    if (!rst_n) begin
      fail_count    <= 0;
      pending_words <= 0;
      expected_words.delete();
    end else begin
      if (in_push && !in_full)
        expected_words.insert(expected_words.size(), evaluate_op(in_mode, in_operand_a,
            in_operand_b, in_operand_c, in_width_a, in_width_b, in_result_width,
            in_slice_low));
      if (out_pop && !out_empty) begin
        if (expected_words.size() == 0) begin
          $error("result word with none expected");
          errs++;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_result !== exp_w.result) begin
            $error("result: expected %h, got %h", exp_w.result, out_result);
            errs++;
          end
          if (out_valid_res !== exp_w.valid_res) begin
            $error("valid_res: expected %b, got %b", exp_w.valid_res, out_valid_res);
            errs++;
          end
        end
      end
      fail_count    <= fail_count + errs;
      pending_words <= expected_words.size();
    end
  end

endmodule

[tb/tb_bitvector_operator_evaluator_unit.sv]
// Testbench top for bitvector_operator_evaluator_unit: drives operator words
// under varied idling and back-pressure. Depends on bvo_pkg and bvo_checker.
`timescale 1ns / 1ps

module tb_bitvector_operator_evaluator_unit;
  import bvo_pkg::*;

  localparam int RANDOM_WORDS = 1760;
  localparam int IDLE_LIMIT   = 20000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  logic              in_full;
  logic [4:0]        in_mode = '0;
  logic [DATA_W-1:0] in_operand_a = '0, in_operand_b = '0, in_operand_c = '0;
  logic [WID_W-1:0]  in_width_a = 7'd1, in_width_b = 7'd1, in_result_width = 7'd1;
  logic [5:0]        in_slice_low = '0;
  logic              out_empty;
  logic              out_pop = 1'b0;
  logic [DATA_W-1:0] out_result;
  logic              out_valid_res;
  int                fail_count, pending_words;
  int                send_idle_pct = 0, recv_stall_pct = 0;
  int                hold_off = 0;
  int                idle_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bitvector_operator_evaluator_unit i_dut (.*);

  bvo_checker i_checker (.*);

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v = '0;
      1: v = '1;
      2: v = 64'($urandom_range(70));
      3: v = v >> $urandom_range(63);
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] rand_width();
    case ($urandom_range(9))
      0: return 7'd64;
      1: return 7'd1;
      2: return 7'($urandom_range(127));
      default: return 7'($urandom_range(64, 1));
    endcase
  endfunction

  // offer one word, hold it until accepted
  task automatic send_word(logic [4:0] mode, logic [63:0] a, logic [63:0] b,
                           logic [63:0] c, logic [6:0] wa, logic [6:0] wb,
                           logic [6:0] wr, logic [5:0] lo);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_mode <= mode;
    in_operand_a <= a;
    in_operand_b <= b;
    in_operand_c <= c;
    in_width_a <= wa;
    in_width_b <= wb;
    in_result_width <= wr;
    in_slice_low <= lo;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic send_random();
    send_word(5'($urandom_range(31)), rand64(), rand64(), rand64(), rand_width(),
              rand_width(), rand_width(), 6'($urandom_range(63)));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: operator codes 0-19 and 26-31 at full width, then corner cases
    for (int m = 0; m < 32; m++)
      if (m < 20 || m > 25)
        send_word(5'(m), 64'hF0F0_1234_8000_0001, 64'd5, 64'hABCD, 7'd64, 7'd64,
                  7'd64, 6'd4);
    send_word(OP_UDIV, '1, '0, '0, 7'd64, 7'd64, 7'd64, '0);
    send_word(OP_UREM, '1, 64'h100, '0, 7'd64, 7'd8, 7'd64, '0);
    send_word(OP_SLT, 64'h80, 64'h7F, '0, 7'd8, 7'd8, 7'd1, '0);
    send_word(OP_SGTE, 64'h80, 64'h7F, '0, 7'd8, 7'd8, 7'd1, '0);
    send_word(OP_SEXT, 64'h1, '0, '0, 7'd0, 7'd0, 7'd127, '0);
    send_word(OP_SRA, 64'h8000_0000_0000_0000, 64'd200, '0, 7'd64, 7'd64, 7'd64, '0);
    send_word(OP_SRA, 64'h80, 64'd3, '0, 7'd8, 7'd64, 7'd16, '0);
    send_word(OP_SLL, '1, 64'd64, '0, 7'd64, 7'd64, 7'd64, '0);
    send_word(OP_CONCAT, '1, 64'h3, '0, 7'd64, 7'd2, 7'd64, '0);
    send_word(OP_ITE, 64'h100, '1, 64'h55, 7'd8, 7'd64, 7'd64, '0);

    // long receiver hold-off while words keep coming: fills the pipeline
    hold_off <= 300;
    for (int i = 0; i < 120; i++) send_random();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 56 : (ph == 3) ? 36 : 0;
      recv_stall_pct = (ph == 2) ? 56 : (ph == 3) ? 36 : 0;
      for (int i = 0; i < RANDOM_WORDS / 4; i++) send_random();
    end
    in_push <= 1'b0;

    while (pending_words != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

[sim.f]
rtl/core/bvo_pkg.sv
rtl/core/bvo_fifo.sv
rtl/core/bvo_front.sv
rtl/core/bvo_div.sv
rtl/core/bvo_exec.sv
rtl/core/bitvector_operator_evaluator_unit.sv
tb/bvo_checker.sv
tb/tb_bitvector_operator_evaluator_unit.sv
